// ===== hdl/cor_pkg.sv =====
// ----------------------------------------------------------------------------
// cor_pkg: shared types and constants for circle overlap resolution
// Fixed-point widths, the sideband record that travels with each pair, and
// the saturation helper for corner positions.
// ----------------------------------------------------------------------------
package cor_pkg;

    localparam int POS_W  = 24;   // corner position, signed Q15.8
    localparam int RAD_W  = 16;   // radius and scale, unsigned Q8.8
    localparam int PRD_W  = 32;   // radius times scale
    localparam int CEN_W  = 25;   // circle centre, signed
    localparam int DIF_W  = 26;   // centre difference, signed
    localparam int MAG_W  = 25;   // magnitude of a centre difference
    localparam int SQ_W   = 50;   // square of a magnitude
    localparam int D2_W   = 51;   // squared distance
    localparam int RS_W   = 17;   // radius sum
    localparam int RSQ_W  = 34;   // squared radius sum, also the root operand
    localparam int ROOT_W = 17;   // square root result
    localparam int REM_W  = 19;   // square root remainder
    localparam int NUM_W  = 34;   // divider dividend
    localparam int DVS_W  = 18;   // divider divisor
    localparam int QUO_W  = 16;   // push magnitude
    localparam int EXT_W  = 26;   // corner plus push before saturation

    localparam logic [RAD_W-1:0] SCALE_RESET = 16'd256;
    localparam logic signed [POS_W-1:0] POS_MAX = 24'sh7FFFFF;
    localparam logic signed [POS_W-1:0] POS_MIN = -24'sh800000;

    typedef struct packed {
        logic signed [POS_W-1:0] x1;
        logic signed [POS_W-1:0] y1;
        logic signed [POS_W-1:0] x2;
        logic signed [POS_W-1:0] y2;
        logic                    sx;
        logic                    sy;
        logic [ROOT_W-1:0]       mx;
        logic [ROOT_W-1:0]       my;
        logic [RS_W-1:0]         rsum;
        logic                    push;
        logic                    overlapping;
        logic                    coincide;
    } side_t;

    function automatic logic signed [POS_W-1:0] sat_pos(input logic signed [EXT_W-1:0] v);
        logic signed [EXT_W-1:0] hi;
        logic signed [EXT_W-1:0] lo;
        begin
            hi = EXT_W'(POS_MAX);
            lo = EXT_W'(POS_MIN);
            if (v > hi)
            begin
                sat_pos = POS_MAX;
            end
            else if (v < lo)
            begin
                sat_pos = POS_MIN;
            end
            else
            begin
                sat_pos = v[POS_W-1:0];
            end
        end
    endfunction

endpackage

// ===== hdl/cor_isqrt_pipe.sv =====
// ----------------------------------------------------------------------------
// cor_isqrt_pipe: pipelined integer square root
// One result bit per stage, digit by digit, with the pair's sideband alongside.
// ----------------------------------------------------------------------------
module cor_isqrt_pipe
    import cor_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  logic              in_valid,
    input  logic [RSQ_W-1:0]  in_rad,
    input  side_t             in_side,
    output logic              out_valid,
    output logic [ROOT_W-1:0] out_root,
    output side_t             out_side
);

    logic [ROOT_W-1:0] valid_reg;
    logic [RSQ_W-1:0]  rad_reg  [ROOT_W];
    logic [REM_W-1:0]  rem_reg  [ROOT_W];
    logic [ROOT_W-1:0] root_reg [ROOT_W];
    side_t             side_reg [ROOT_W];

    genvar g;
    generate
        for (g = 0; g < ROOT_W; g++)
        begin : g_stage
            logic              v_in;
            logic [RSQ_W-1:0]  rad_in;
            logic [REM_W-1:0]  rem_in;
            logic [ROOT_W-1:0] root_in;
            side_t             side_in;
            logic [REM_W-1:0]  rem_sh;
            logic [REM_W-1:0]  trial;

            if (g == 0)
            begin : g_first
                assign v_in    = in_valid;
                assign rad_in  = in_rad;
                assign rem_in  = '0;
                assign root_in = '0;
                assign side_in = in_side;
            end
            else
            begin : g_next
                assign v_in    = valid_reg[g-1];
                assign rad_in  = rad_reg[g-1];
                assign rem_in  = rem_reg[g-1];
                assign root_in = root_reg[g-1];
                assign side_in = side_reg[g-1];
            end

            // Bring down the next two operand bits and try the new root bit.
            assign rem_sh = {rem_in[REM_W-3:0], rad_in[RSQ_W-1 -: 2]};
            assign trial  = {root_in, 2'b01};

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    valid_reg[g] <= 1'b0;
                end
                else if (en)
                begin
                    valid_reg[g] <= v_in;
                end
            end

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    rad_reg[g]  <= {rad_in[RSQ_W-3:0], 2'b00};
                    side_reg[g] <= side_in;
                    if (rem_sh >= trial)
                    begin
                        rem_reg[g]  <= rem_sh - trial;
                        root_reg[g] <= {root_in[ROOT_W-2:0], 1'b1};
                    end
                    else
                    begin
                        rem_reg[g]  <= rem_sh;
                        root_reg[g] <= {root_in[ROOT_W-2:0], 1'b0};
                    end
                end
            end
        end
    endgenerate

    assign out_valid = valid_reg[ROOT_W-1];
    assign out_root  = root_reg[ROOT_W-1];
    assign out_side  = side_reg[ROOT_W-1];

endmodule

// ===== hdl/cor_div_pipe.sv =====
// ----------------------------------------------------------------------------
// cor_div_pipe: pipelined restoring divider, two lanes with a shared divisor
// One quotient bit per stage for the x and y push magnitudes.
// ----------------------------------------------------------------------------
module cor_div_pipe
    import cor_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             en,
    input  logic             in_valid,
    input  logic [NUM_W-1:0] in_num_x,
    input  logic [NUM_W-1:0] in_num_y,
    input  logic [DVS_W-1:0] in_den,
    input  side_t            in_side,
    output logic             out_valid,
    output logic [QUO_W-1:0] out_quo_x,
    output logic [QUO_W-1:0] out_quo_y,
    output side_t            out_side
);

    logic [QUO_W-1:0] valid_reg;
    logic [NUM_W-1:0] remx_reg [QUO_W];
    logic [NUM_W-1:0] remy_reg [QUO_W];
    logic [QUO_W-1:0] qx_reg   [QUO_W];
    logic [QUO_W-1:0] qy_reg   [QUO_W];
    logic [DVS_W-1:0] den_reg  [QUO_W];
    side_t            side_reg [QUO_W];

    genvar g;
    generate
        for (g = 0; g < QUO_W; g++)
        begin : g_stage
            logic             v_in;
            logic [NUM_W-1:0] remx_in;
            logic [NUM_W-1:0] remy_in;
            logic [QUO_W-1:0] qx_in;
            logic [QUO_W-1:0] qy_in;
            logic [DVS_W-1:0] den_in;
            side_t            side_in;
            logic [NUM_W-1:0] dsh;

            if (g == 0)
            begin : g_first
                assign v_in    = in_valid;
                assign remx_in = in_num_x;
                assign remy_in = in_num_y;
                assign qx_in   = '0;
                assign qy_in   = '0;
                assign den_in  = in_den;
                assign side_in = in_side;
            end
            else
            begin : g_next
                assign v_in    = valid_reg[g-1];
                assign remx_in = remx_reg[g-1];
                assign remy_in = remy_reg[g-1];
                assign qx_in   = qx_reg[g-1];
                assign qy_in   = qy_reg[g-1];
                assign den_in  = den_reg[g-1];
                assign side_in = side_reg[g-1];
            end

            // Divisor aligned to the quotient bit decided in this stage.
            assign dsh = NUM_W'(den_in) << (QUO_W - 1 - g);

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    valid_reg[g] <= 1'b0;
                end
                else if (en)
                begin
                    valid_reg[g] <= v_in;
                end
            end

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    den_reg[g]  <= den_in;
                    side_reg[g] <= side_in;
                    if (remx_in >= dsh)
                    begin
                        remx_reg[g] <= remx_in - dsh;
                        qx_reg[g]   <= qx_in | (QUO_W'(1) << (QUO_W - 1 - g));
                    end
                    else
                    begin
                        remx_reg[g] <= remx_in;
                        qx_reg[g]   <= qx_in;
                    end
                    if (remy_in >= dsh)
                    begin
                        remy_reg[g] <= remy_in - dsh;
                        qy_reg[g]   <= qy_in | (QUO_W'(1) << (QUO_W - 1 - g));
                    end
                    else
                    begin
                        remy_reg[g] <= remy_in;
                        qy_reg[g]   <= qy_in;
                    end
                end
            end
        end
    endgenerate

    assign out_valid = valid_reg[QUO_W-1];
    assign out_quo_x = qx_reg[QUO_W-1];
    assign out_quo_y = qy_reg[QUO_W-1];
    assign out_side  = side_reg[QUO_W-1];

endmodule

// ===== hdl/circle_overlap_resolve_core.sv =====
// ----------------------------------------------------------------------------
// circle_overlap_resolve_core: circle pair collision resolution
// Scales both radii, measures the centre distance and pushes overlapping
// circles apart by half the overlap each, in Q15.8 fixed point.
// ----------------------------------------------------------------------------
// A new circle pair may be transferred on every clock cycle while the output
// side does not stall, and each pair yields exactly one result, in order.
// The pipeline has 42 register stages: eight stages of scaling, centre,
// squaring, comparison and product logic, a 17-stage square root that
// settles one root bit per stage, and a 16-stage divider that settles one
// bit of both push magnitudes per stage, followed by the output register.
// The whole pipeline advances together: it moves whenever the output
// register is empty or its result is being transferred, so a stall on the
// output holds every stage and nothing is lost or repeated.
// The sprite_scale register is written through the configuration channel,
// which is always ready; it should only be written while no pair is in
// flight. When two circles with a nonzero radius sum share a centre no push
// is applied and centers_coincide is raised instead.
// ----------------------------------------------------------------------------
module circle_overlap_resolve_core
    import cor_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    cfg_valid,
    output logic                    cfg_ready,
    input  logic [RAD_W-1:0]        cfg_data,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  logic signed [POS_W-1:0] first_x,
    input  logic signed [POS_W-1:0] first_y,
    input  logic [RAD_W-1:0]        first_radius,
    input  logic signed [POS_W-1:0] second_x,
    input  logic signed [POS_W-1:0] second_y,
    input  logic [RAD_W-1:0]        second_radius,
    output logic                    out_valid,
    input  logic                    out_ready,
    output logic signed [POS_W-1:0] new_first_x,
    output logic signed [POS_W-1:0] new_first_y,
    output logic signed [POS_W-1:0] new_second_x,
    output logic signed [POS_W-1:0] new_second_y,
    output logic                    overlapping,
    output logic                    centers_coincide
);

    // The pipeline advances when the output register can take a new result.
    logic out_valid_reg;
    logic en;
    assign en        = !out_valid_reg || out_ready;
    assign in_ready  = en;
    assign cfg_ready = 1'b1;

    logic [RAD_W-1:0] scale_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scale_reg <= SCALE_RESET;
        end
        else if (cfg_valid)
        begin
            scale_reg <= cfg_data;
        end
    end

    // Outputs of the square root and of the divider.
    logic              sq_valid;
    logic [ROOT_W-1:0] sq_root;
    side_t             sq_side;
    logic              dv_valid;
    logic [QUO_W-1:0]  dv_qx, dv_qy;
    side_t             dv_side;

    // Stage valid bits.
    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg, v6_reg, v7_reg, v8_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            v3_reg        <= 1'b0;
            v4_reg        <= 1'b0;
            v5_reg        <= 1'b0;
            v6_reg        <= 1'b0;
            v7_reg        <= 1'b0;
            v8_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg        <= in_valid;
            v2_reg        <= v1_reg;
            v3_reg        <= v2_reg;
            v4_reg        <= v3_reg;
            v5_reg        <= v4_reg;
            v6_reg        <= v5_reg;
            v7_reg        <= sq_valid;
            v8_reg        <= v7_reg;
            out_valid_reg <= dv_valid;
        end
    end

    // Stage 1: register the corners and multiply the radii by the scale.
    logic signed [POS_W-1:0] x1_1_reg, y1_1_reg, x2_1_reg, y2_1_reg;
    logic [PRD_W-1:0]        p1_1_reg, p2_1_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x1_1_reg <= first_x;
            y1_1_reg <= first_y;
            x2_1_reg <= second_x;
            y2_1_reg <= second_y;
            p1_1_reg <= PRD_W'(first_radius) * PRD_W'(scale_reg);
            p2_1_reg <= PRD_W'(second_radius) * PRD_W'(scale_reg);
        end
    end

    // Stage 2: drop the fraction bits of the product, saturate, form centres.
    logic [RAD_W-1:0]        r1s, r2s;
    logic signed [POS_W-1:0] x1_2_reg, y1_2_reg, x2_2_reg, y2_2_reg;
    logic signed [CEN_W-1:0] c1x_reg, c1y_reg, c2x_reg, c2y_reg;
    logic [RAD_W-1:0]        r1s_reg, r2s_reg;

    assign r1s = (|p1_1_reg[PRD_W-1:RAD_W+8]) ? '1 : p1_1_reg[RAD_W+7:8];
    assign r2s = (|p2_1_reg[PRD_W-1:RAD_W+8]) ? '1 : p2_1_reg[RAD_W+7:8];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x1_2_reg <= x1_1_reg;
            y1_2_reg <= y1_1_reg;
            x2_2_reg <= x2_1_reg;
            y2_2_reg <= y2_1_reg;
            c1x_reg  <= CEN_W'(x1_1_reg) + $signed({1'b0, r1s});
            c1y_reg  <= CEN_W'(y1_1_reg) + $signed({1'b0, r1s});
            c2x_reg  <= CEN_W'(x2_1_reg) + $signed({1'b0, r2s});
            c2y_reg  <= CEN_W'(y2_1_reg) + $signed({1'b0, r2s});
            r1s_reg  <= r1s;
            r2s_reg  <= r2s;
        end
    end

    // Stage 3: centre differences, their signs and magnitudes, radius sum.
    logic signed [DIF_W-1:0] dx, dy;
    logic signed [DIF_W-1:0] ndx, ndy;
    logic signed [POS_W-1:0] x1_3_reg, y1_3_reg, x2_3_reg, y2_3_reg;
    logic                    sx_3_reg, sy_3_reg;
    logic [MAG_W-1:0]        mx_3_reg, my_3_reg;
    logic [RS_W-1:0]         rsum_3_reg;

    assign dx  = DIF_W'(c2x_reg) - DIF_W'(c1x_reg);
    assign dy  = DIF_W'(c2y_reg) - DIF_W'(c1y_reg);
    assign ndx = -dx;
    assign ndy = -dy;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x1_3_reg   <= x1_2_reg;
            y1_3_reg   <= y1_2_reg;
            x2_3_reg   <= x2_2_reg;
            y2_3_reg   <= y2_2_reg;
            sx_3_reg   <= dx[DIF_W-1];
            sy_3_reg   <= dy[DIF_W-1];
            mx_3_reg   <= dx[DIF_W-1] ? ndx[MAG_W-1:0] : dx[MAG_W-1:0];
            my_3_reg   <= dy[DIF_W-1] ? ndy[MAG_W-1:0] : dy[MAG_W-1:0];
            rsum_3_reg <= RS_W'(r1s_reg) + RS_W'(r2s_reg);
        end
    end

    // Stage 4: squares of both magnitudes and of the radius sum.
    logic signed [POS_W-1:0] x1_4_reg, y1_4_reg, x2_4_reg, y2_4_reg;
    logic                    sx_4_reg, sy_4_reg;
    logic [ROOT_W-1:0]       mx_4_reg, my_4_reg;
    logic [RS_W-1:0]         rsum_4_reg;
    logic [SQ_W-1:0]         sqx_reg, sqy_reg;
    logic [RSQ_W-1:0]        rsq_4_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x1_4_reg   <= x1_3_reg;
            y1_4_reg   <= y1_3_reg;
            x2_4_reg   <= x2_3_reg;
            y2_4_reg   <= y2_3_reg;
            sx_4_reg   <= sx_3_reg;
            sy_4_reg   <= sy_3_reg;
            mx_4_reg   <= mx_3_reg[ROOT_W-1:0];
            my_4_reg   <= my_3_reg[ROOT_W-1:0];
            rsum_4_reg <= rsum_3_reg;
            sqx_reg    <= SQ_W'(mx_3_reg) * SQ_W'(mx_3_reg);
            sqy_reg    <= SQ_W'(my_3_reg) * SQ_W'(my_3_reg);
            rsq_4_reg  <= RSQ_W'(rsum_3_reg) * RSQ_W'(rsum_3_reg);
        end
    end

    // Stage 5: squared centre distance.
    logic signed [POS_W-1:0] x1_5_reg, y1_5_reg, x2_5_reg, y2_5_reg;
    logic                    sx_5_reg, sy_5_reg;
    logic [ROOT_W-1:0]       mx_5_reg, my_5_reg;
    logic [RS_W-1:0]         rsum_5_reg;
    logic [RSQ_W-1:0]        rsq_5_reg;
    logic [D2_W-1:0]         d2_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x1_5_reg   <= x1_4_reg;
            y1_5_reg   <= y1_4_reg;
            x2_5_reg   <= x2_4_reg;
            y2_5_reg   <= y2_4_reg;
            sx_5_reg   <= sx_4_reg;
            sy_5_reg   <= sy_4_reg;
            mx_5_reg   <= mx_4_reg;
            my_5_reg   <= my_4_reg;
            rsum_5_reg <= rsum_4_reg;
            rsq_5_reg  <= rsq_4_reg;
            d2_reg     <= D2_W'(sqx_reg) + D2_W'(sqy_reg);
        end
    end

    // Stage 6: classify the pair. The floored distance is below the radius
    // sum exactly when the squared distance is below the squared sum, so the
    // push decision needs no root. A push implies the squared distance fits
    // the root operand and each magnitude fits the root width.
    logic  strictly_inside;
    side_t side_6;
    side_t side_6_reg;
    logic [RSQ_W-1:0] rad_6_reg;

    assign strictly_inside = d2_reg < D2_W'(rsq_5_reg);

    always_comb
    begin
        side_6             = '0;
        side_6.x1          = x1_5_reg;
        side_6.y1          = y1_5_reg;
        side_6.x2          = x2_5_reg;
        side_6.y2          = y2_5_reg;
        side_6.sx          = sx_5_reg;
        side_6.sy          = sy_5_reg;
        side_6.mx          = mx_5_reg;
        side_6.my          = my_5_reg;
        side_6.rsum        = rsum_5_reg;
        side_6.overlapping = d2_reg <= D2_W'(rsq_5_reg);
        side_6.push        = strictly_inside && (d2_reg != '0);
        side_6.coincide    = strictly_inside && (d2_reg == '0);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            side_6_reg <= side_6;
            rad_6_reg  <= d2_reg[RSQ_W-1:0];
        end
    end

    // Square root of the squared distance.
    cor_isqrt_pipe u_isqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (v6_reg),
        .in_rad    (rad_6_reg),
        .in_side   (side_6_reg),
        .out_valid (sq_valid),
        .out_root  (sq_root),
        .out_side  (sq_side)
    );

    // Stage 7: overlap is the radius sum minus the distance.
    logic [RS_W-1:0]   overlap_reg;
    logic [ROOT_W-1:0] root_7_reg;
    side_t             side_7_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            overlap_reg <= sq_side.rsum - RS_W'(sq_root);
            root_7_reg  <= sq_root;
            side_7_reg  <= sq_side;
        end
    end

    // Stage 8: dividends for the push on each axis and twice the distance.
    logic [NUM_W-1:0] numx_reg, numy_reg;
    logic [DVS_W-1:0] den_reg;
    side_t            side_8_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            numx_reg   <= NUM_W'(side_7_reg.mx) * NUM_W'(overlap_reg);
            numy_reg   <= NUM_W'(side_7_reg.my) * NUM_W'(overlap_reg);
            den_reg    <= {root_7_reg, 1'b0};
            side_8_reg <= side_7_reg;
        end
    end

    cor_div_pipe u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (v8_reg),
        .in_num_x  (numx_reg),
        .in_num_y  (numy_reg),
        .in_den    (den_reg),
        .in_side   (side_8_reg),
        .out_valid (dv_valid),
        .out_quo_x (dv_qx),
        .out_quo_y (dv_qy),
        .out_side  (dv_side)
    );

    // Output stage: apply the push away from the other circle and saturate.
    // A negative difference means the second circle lies on the low side.
    logic signed [EXT_W-1:0] qx_e, qy_e;
    logic signed [EXT_W-1:0] x1_e, y1_e, x2_e, y2_e;
    logic signed [EXT_W-1:0] nx1, ny1, nx2, ny2;
    logic signed [POS_W-1:0] nfx_reg, nfy_reg, nsx_reg, nsy_reg;
    logic                    ovl_reg, coin_reg;

    assign qx_e = $signed(EXT_W'(dv_qx));
    assign qy_e = $signed(EXT_W'(dv_qy));
    assign x1_e = EXT_W'(dv_side.x1);
    assign y1_e = EXT_W'(dv_side.y1);
    assign x2_e = EXT_W'(dv_side.x2);
    assign y2_e = EXT_W'(dv_side.y2);
    assign nx1  = dv_side.sx ? x1_e + qx_e : x1_e - qx_e;
    assign nx2  = dv_side.sx ? x2_e - qx_e : x2_e + qx_e;
    assign ny1  = dv_side.sy ? y1_e + qy_e : y1_e - qy_e;
    assign ny2  = dv_side.sy ? y2_e - qy_e : y2_e + qy_e;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ovl_reg  <= dv_side.overlapping;
            coin_reg <= dv_side.coincide;
            if (dv_side.push)
            begin
                nfx_reg <= sat_pos(nx1);
                nfy_reg <= sat_pos(ny1);
                nsx_reg <= sat_pos(nx2);
                nsy_reg <= sat_pos(ny2);
            end
            else
            begin
                nfx_reg <= dv_side.x1;
                nfy_reg <= dv_side.y1;
                nsx_reg <= dv_side.x2;
                nsy_reg <= dv_side.y2;
            end
        end
    end

    assign out_valid        = out_valid_reg;
    assign new_first_x      = nfx_reg;
    assign new_first_y      = nfy_reg;
    assign new_second_x     = nsx_reg;
    assign new_second_y     = nsy_reg;
    assign overlapping      = ovl_reg;
    assign centers_coincide = coin_reg;

    // Coincident centres can only be reported for an overlapping pair.
    a_coincide_overlaps : assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && centers_coincide |-> overlapping)
        else $error("centres reported coincident without overlap");

    // A push and coincident centres exclude each other, and a push needs overlap.
    a_push_class : assert property (@(posedge clk) disable iff (!rst_n)
        v6_reg && side_6_reg.push |-> side_6_reg.overlapping && !side_6_reg.coincide)
        else $error("inconsistent pair classification");

    // A configuration transfer lands in the scale register on the next cycle.
    a_cfg_write : assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid && cfg_ready |=> scale_reg == $past(cfg_data))
        else $error("scale register not updated by configuration transfer");

endmodule

// ===== tb/sv/tb_circle_overlap_resolve_core.sv =====
// ----------------------------------------------------------------------------
// tb_circle_overlap_resolve_core: testbench for circle pair collision resolution
// Streams circle pairs through the core under random sender bursts and
// receiver stalls, predicts each result in the testbench and compares every
// transferred result field by field, across several sprite_scale settings.
// ----------------------------------------------------------------------------
module tb_circle_overlap_resolve_core;
    import cor_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int DRAIN_CYCLES = 80;     // pipeline latency plus margin
    localparam int WATCHDOG_LIMIT = 20000;

    // One circle pair as it is offered to the core.
    typedef struct {
        logic signed [POS_W-1:0] x1;
        logic signed [POS_W-1:0] y1;
        logic [RAD_W-1:0]        r1;
        logic signed [POS_W-1:0] x2;
        logic signed [POS_W-1:0] y2;
        logic [RAD_W-1:0]        r2;
    } pair_t;

    // One resolved pair as the core should return it.
    typedef struct {
        logic signed [POS_W-1:0] nx1;
        logic signed [POS_W-1:0] ny1;
        logic signed [POS_W-1:0] nx2;
        logic signed [POS_W-1:0] ny2;
        logic                    ovl;
        logic                    coin;
    } resolved_t;

    logic clk;
    logic rst_n;
    logic cfg_valid;
    logic cfg_ready;
    logic [RAD_W-1:0] cfg_data;
    logic in_valid;
    logic in_ready;
    logic signed [POS_W-1:0] first_x;
    logic signed [POS_W-1:0] first_y;
    logic [RAD_W-1:0] first_radius;
    logic signed [POS_W-1:0] second_x;
    logic signed [POS_W-1:0] second_y;
    logic [RAD_W-1:0] second_radius;
    logic out_valid;
    logic out_ready;
    logic signed [POS_W-1:0] new_first_x;
    logic signed [POS_W-1:0] new_first_y;
    logic signed [POS_W-1:0] new_second_x;
    logic signed [POS_W-1:0] new_second_y;
    logic overlapping;
    logic centers_coincide;

    pair_t     pending_pairs[$];
    resolved_t expected_results[$];
    logic [RAD_W-1:0] scale_now;
    int  error_count;
    int  idle_cycles;
    int  burst_left;
    int  gap_left;
    int  stall_phase;
    bit  hold_sender;
    bit  timed_out;

    circle_overlap_resolve_core dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_data        (cfg_data),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .first_x         (first_x),
        .first_y         (first_y),
        .first_radius    (first_radius),
        .second_x        (second_x),
        .second_y        (second_y),
        .second_radius   (second_radius),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .new_first_x     (new_first_x),
        .new_first_y     (new_first_y),
        .new_second_x    (new_second_x),
        .new_second_y    (new_second_y),
        .overlapping     (overlapping),
        .centers_coincide(centers_coincide)
    );

    always #10 clk = ~clk;

    // Integer square root, rounded down, by the digit-by-digit method.
    function automatic longint unsigned floor_root(input longint unsigned n);
        longint unsigned res;
        longint unsigned bitv;
        res = 0;
        bitv = 64'd1 << 62;
        while (bitv > n)
            bitv = bitv >> 2;
        while (bitv != 0)
        begin
            if (n >= res + bitv)
            begin
                n = n - (res + bitv);
                res = (res >> 1) + bitv;
            end
            else
            begin
                res = res >> 1;
            end
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    function automatic longint clamp_corner(input longint v);
        if (v > 64'sd8388607)
            return 64'sd8388607;
        if (v < -64'sd8388608)
            return -64'sd8388608;
        return v;
    endfunction

    // Push along one axis: half the overlap scaled by the axis share of the
    // distance, truncated toward zero.
    function automatic longint axis_push(input longint d, input longint unsigned ovl,
                                         input longint unsigned centre_dist);
        longint unsigned mag;
        longint unsigned q;
        mag = (d < 0) ? longint'(-d) : longint'(d);
        q = (mag * ovl) / (2 * centre_dist);
        return (d < 0) ? -longint'(q) : longint'(q);
    endfunction

    function automatic longint unsigned scaled_radius(input logic [RAD_W-1:0] r,
                                                      input logic [RAD_W-1:0] s);
        longint unsigned p;
        p = (longint'(r) * longint'(s)) >> 8;
        return (p > 65535) ? 65535 : p;
    endfunction

    // Works out the resolved positions and flags for one pair.
    function automatic resolved_t resolve_pair(input pair_t p, input logic [RAD_W-1:0] s);
        resolved_t res;
        longint unsigned r1s;
        longint unsigned r2s;
        longint unsigned rsum;
        longint unsigned adx;
        longint unsigned ady;
        longint unsigned d2;
        longint unsigned centre_dist;
        longint dx;
        longint dy;
        longint ox;
        longint oy;
        r1s = scaled_radius(p.r1, s);
        r2s = scaled_radius(p.r2, s);
        dx = (longint'(p.x2) + longint'(r2s)) - (longint'(p.x1) + longint'(r1s));
        dy = (longint'(p.y2) + longint'(r2s)) - (longint'(p.y1) + longint'(r1s));
        adx = (dx < 0) ? -dx : dx;
        ady = (dy < 0) ? -dy : dy;
        d2 = adx * adx + ady * ady;
        rsum = r1s + r2s;
        centre_dist = floor_root(d2);
        res.nx1 = p.x1;
        res.ny1 = p.y1;
        res.nx2 = p.x2;
        res.ny2 = p.y2;
        res.ovl = (d2 <= rsum * rsum);
        res.coin = 1'b0;
        if (rsum > centre_dist)
        begin
            if (centre_dist == 0)
            begin
                res.coin = 1'b1;
            end
            else
            begin
                ox = axis_push(dx, rsum - centre_dist, centre_dist);
                oy = axis_push(dy, rsum - centre_dist, centre_dist);
                res.nx1 = POS_W'(clamp_corner(longint'(p.x1) - ox));
                res.ny1 = POS_W'(clamp_corner(longint'(p.y1) - oy));
                res.nx2 = POS_W'(clamp_corner(longint'(p.x2) + ox));
                res.ny2 = POS_W'(clamp_corner(longint'(p.y2) + oy));
            end
        end
        return res;
    endfunction

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("MISMATCH %s: got %0d, expected %0d at %0t", what, got, want, $realtime);
        error_count++;
    endtask

    function automatic pair_t make_pair(input longint x1, input longint y1, input longint r1,
                                        input longint x2, input longint y2, input longint r2);
        pair_t p;
        p.x1 = POS_W'(x1);
        p.y1 = POS_W'(y1);
        p.r1 = RAD_W'(r1);
        p.x2 = POS_W'(x2);
        p.y2 = POS_W'(y2);
        p.r2 = RAD_W'(r2);
        return p;
    endfunction

    // Random pair, mostly near each other so that pushes occur often; some
    // fully random ones cover every bit, and some sit at the saturation corners.
    function automatic pair_t random_pair();
        pair_t p;
        int kind;
        int span;
        kind = $urandom_range(0, 9);
        p.x1 = POS_W'($urandom);
        p.y1 = POS_W'($urandom);
        p.r1 = RAD_W'($urandom);
        p.r2 = RAD_W'($urandom);
        if (kind < 2)
        begin
            p.x2 = POS_W'($urandom);
            p.y2 = POS_W'($urandom);
        end
        else
        begin
            span = (kind < 5) ? 64 : 20000;
            if (kind < 5)
            begin
                p.r1 = RAD_W'($urandom_range(0, 32));
                p.r2 = RAD_W'($urandom_range(0, 32));
            end
            else if (kind < 7)
            begin
                p.r1 = RAD_W'($urandom_range(0, 8000));
                p.r2 = RAD_W'($urandom_range(0, 8000));
            end
            if (kind == 9)
            begin
                // Push the pair against the ends of the position range.
                p.x1 = ($urandom_range(0, 1) != 0) ? POS_W'(POS_MAX - $urandom_range(0, 300))
                                                   : POS_W'(POS_MIN + $urandom_range(0, 300));
                p.y1 = ($urandom_range(0, 1) != 0) ? POS_W'(POS_MAX - $urandom_range(0, 300))
                                                   : POS_W'(POS_MIN + $urandom_range(0, 300));
            end
            p.x2 = POS_W'(p.x1 + $signed($urandom_range(0, 2 * span)) - span);
            p.y2 = POS_W'(p.y1 + $signed($urandom_range(0, 2 * span)) - span);
            if (kind == 4)
            begin
                // Same radii and corners give coincident centres.
                p.x2 = p.x1;
                p.y2 = p.y1;
                p.r2 = p.r1;
            end
        end
        return p;
    endfunction

    // Sender: bursts of transfers with random gaps. A pair is taken from the
    // queue only when the previous one has been transferred, so valid never
    // drops while an item waits.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            burst_left <= 0;
            gap_left <= 0;
        end
        else if (!in_valid || in_ready)
        begin
            if (in_valid)
                expected_results.push_back(resolve_pair(make_pair(first_x, first_y,
                    first_radius, second_x, second_y, second_radius), scale_now));
            if (gap_left > 0)
            begin
                gap_left <= gap_left - 1;
                in_valid <= 1'b0;
            end
            else if (pending_pairs.size() != 0 && !hold_sender)
            begin
                pair_t p;
                p = pending_pairs.pop_front();
                in_valid <= 1'b1;
                first_x <= p.x1;
                first_y <= p.y1;
                first_radius <= p.r1;
                second_x <= p.x2;
                second_y <= p.y2;
                second_radius <= p.r2;
                if (burst_left <= 1)
                begin
                    burst_left <= $urandom_range(1, 30);
                    gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
                end
                else
                begin
                    burst_left <= burst_left - 1;
                end
            end
            else
            begin
                in_valid <= 1'b0;
            end
        end
    end

    // Receiver: stalls follow a rotating phase pattern, with ready-only stretches.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            stall_phase <= 0;
        end
        else
        begin
            stall_phase <= (stall_phase + 1) % 64;
            if (stall_phase < 20)
                out_ready <= 1'b1;
            else if (stall_phase < 40)
                out_ready <= ($urandom_range(0, 3) != 0);
            else
                out_ready <= (stall_phase % 3 != 0) && ($urandom_range(0, 1) != 0);
        end
    end

    // Monitor: every transferred result is checked against the oldest prediction.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_results.size() == 0)
            begin
                report_mismatch("unexpected result", 1, 0);
            end
            else
            begin
                resolved_t e;
                e = expected_results.pop_front();
                if (new_first_x !== e.nx1)
                    report_mismatch("new_first_x", new_first_x, e.nx1);
                if (new_first_y !== e.ny1)
                    report_mismatch("new_first_y", new_first_y, e.ny1);
                if (new_second_x !== e.nx2)
                    report_mismatch("new_second_x", new_second_x, e.nx2);
                if (new_second_y !== e.ny2)
                    report_mismatch("new_second_y", new_second_y, e.ny2);
                if (overlapping !== e.ovl)
                    report_mismatch("overlapping", overlapping, e.ovl);
                if (centers_coincide !== e.coin)
                    report_mismatch("centers_coincide", centers_coincide, e.coin);
            end
        end
    end

    // Watchdog: counts cycles in which no transfer happens on either channel.
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || !rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT && !timed_out)
        begin
            timed_out = 1'b1;
            $display("Verification failed");
            $finish;
        end
    end

    // Waits until the sender has nothing left and every result has come back.
    task automatic wait_drained();
        while (pending_pairs.size() != 0 || in_valid || expected_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_scale(input logic [RAD_W-1:0] value);
        cfg_data <= value;
        cfg_valid <= 1'b1;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        scale_now = value;
        cfg_valid <= 1'b0;
    endtask

    initial
    begin
        logic [RAD_W-1:0] scales[5];
        clk = 1'b0;
        rst_n = 1'b0;
        cfg_valid = 1'b0;
        cfg_data = '0;
        in_valid = 1'b0;
        out_ready = 1'b0;
        first_x = '0;
        first_y = '0;
        first_radius = '0;
        second_x = '0;
        second_y = '0;
        second_radius = '0;
        error_count = 0;
        idle_cycles = 0;
        hold_sender = 1'b0;
        timed_out = 1'b0;
        scale_now = SCALE_RESET;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed pairs at the reset scale of one.
        pending_pairs.push_back(make_pair(0, 0, 256, 100, 0, 256));        // plain push on x
        pending_pairs.push_back(make_pair(0, 0, 256, 0, -100, 256));       // push on y
        pending_pairs.push_back(make_pair(0, 0, 256, 1000, 1000, 256));    // apart
        pending_pairs.push_back(make_pair(50, 60, 300, 50, 60, 300));      // coincident centres
        pending_pairs.push_back(make_pair(5, 5, 0, 5, 5, 0));              // zero radii, one point
        pending_pairs.push_back(make_pair(0, 0, 256, 1024, 0, 256));       // apart on x, distance twice the radius sum
        pending_pairs.push_back(make_pair(8388607, 8388607, 65535, 8388000, 8388000, 65535));
        pending_pairs.push_back(make_pair(-8388608, -8388608, 65535, -8388000, -8388600,
                                          65535));
        pending_pairs.push_back(make_pair(-8388608, 8388607, 0, 8388607, -8388608, 65535));
        pending_pairs.push_back(make_pair(100, 200, 65535, 300, 100, 1));
        pending_pairs.push_back(make_pair(-300, -300, 700, 300, 300, 700));
        wait_drained();

        // Pause the sender once, part way through, until every result is back.
        for (int i = 0; i < 10; i++)
            pending_pairs.push_back(random_pair());
        repeat (4) @(posedge clk);
        hold_sender = 1'b1;
        while (in_valid || expected_results.size() != 0)
            @(posedge clk);
        hold_sender = 1'b0;
        wait_drained();

        // Random phases across scale settings, the extremes among them.
        scales[0] = 16'd0;
        scales[1] = 16'hFFFF;
        scales[2] = 16'd128;
        scales[3] = RAD_W'($urandom);
        scales[4] = SCALE_RESET;
        foreach (scales[k])
        begin
            write_scale(scales[k]);
            pending_pairs.push_back(make_pair(0, 0, 65535, 256, 0, 65535));
            pending_pairs.push_back(make_pair(10, 10, 400, 10, 10, 400));
            for (int i = 0; i < 80; i++)
                pending_pairs.push_back(random_pair());
            wait_drained();
        end

        if (error_count == 0)
        begin
            $display("Verification passed");
        end
        else
        begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
